// ----- hw/rtl/brd_pkg.sv -----
// Shared widths and item types of the bitmap RLE span decoder.
package brd_pkg;

  localparam int CODE_W    = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 8;
  localparam int COLOR_W   = 8;
  localparam int STATUS_W  = 2;

  // Register values after reset.
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  typedef struct packed {
    logic [CODE_W-1:0] code_byte;
    logic              start_of_image;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]    span_col;
    logic [POS_W-1:0]    span_row;
    logic [LEN_W-1:0]    span_length;
    logic [COLOR_W-1:0]  color_even;
    logic [COLOR_W-1:0]  color_odd;
    logic [STATUS_W-1:0] status;
  } span_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic             four_bit_mode;
    logic             top_down;
  } cfg_t;

endpackage

// ----- hw/rtl/brd_in_if.sv -----
// Channel carrying code bytes into the decoder.
interface brd_in_if import brd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;
  logic              start_of_image;

  modport source (output valid, code_byte, start_of_image, input ready);
  modport sink (input valid, code_byte, start_of_image, output ready);
endinterface

// ----- hw/rtl/brd_out_if.sv -----
// Channel carrying pixel spans out of the decoder.
interface brd_out_if import brd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    span_col;
  logic [POS_W-1:0]    span_row;
  logic [LEN_W-1:0]    span_length;
  logic [COLOR_W-1:0]  color_even;
  logic [COLOR_W-1:0]  color_odd;
  logic [STATUS_W-1:0] status;

  modport source (output valid, span_col, span_row, span_length, color_even, color_odd,
                  status, input ready);
  modport sink (input valid, span_col, span_row, span_length, color_even, color_odd,
                status, output ready);
endinterface

// ----- hw/rtl/brd_in_stage.sv -----
// Input register: holds one code byte until the parser takes it.
module brd_in_stage import brd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  brd_in_if.sink   code_i,
  input  logic     take_i,
  output logic     valid_o,
  output item_t    item_o
);

  logic  valid_q;
  item_t item_q;

  // Refill in the same cycle the held item moves on.
  assign code_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (code_i.ready) begin
      valid_q <= code_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_i.ready && code_i.valid) begin
      item_q.code_byte      <= code_i.code_byte;
      item_q.start_of_image <= code_i.start_of_image;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/brd_parser.sv -----
// Code parser: position and count state plus the per-byte span logic.
module brd_parser import brd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  res_valid_o,
  output span_t res_o
);

  // Column never passes MAX_DIM + 255; one spare bit keeps sums clean.
  localparam int WW = $clog2(MAX_DIM + 256) + 1;
  localparam int RW = WW + 1;
  localparam int XW = (WW > CFG_W) ? WW : CFG_W;
  localparam int ROW_RST = ((HEIGHT_RST > MAX_DIM) ? MAX_DIM : HEIGHT_RST) - 1;
  localparam int NIB_W = 4;

  localparam logic [CODE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [CODE_W-1:0] ESC_EOI   = 8'd1;
  localparam logic [CODE_W-1:0] ESC_DELTA = 8'd2;

  localparam logic [STATUS_W-1:0] ST_RUNNING   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ROW_RANGE = 2'd3;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_RUN   = 3'd1,
    PH_ESC   = 3'd2,
    PH_DX    = 3'd3,
    PH_DY    = 3'd4,
    PH_LIT   = 3'd5,
    PH_PAD   = 3'd6
  } phase_e;

  phase_e                  phase_q, phase_d, cur_phase;
  logic [WW-1:0]           col_q, col_d, cur_col;
  logic signed [RW-1:0]    row_q, row_d, cur_row;
  logic [CODE_W-1:0]       rc_q, rc_d, cur_rc;
  logic [CODE_W-1:0]       lit_q, lit_d, cur_lit;
  logic                    pad_q, pad_d, cur_pad;
  logic                    stop_q, stop_d, cur_stop;

  logic [WW-1:0]           eff_w, eff_h;
  logic [CODE_W-1:0]       b, b_dec, lit_n, span_n, clip_n, res_len;
  logic [WW-1:0]           avail, dy_sum, span_end;
  logic                    dy_wrap, code_end, emit_span, pos_in;
  logic [CODE_W:0]         dy_amt;
  logic signed [RW-1:0]    dy_step, row_dir_step, row_one, row_dy;
  logic [STATUS_W-1:0]     status;

  function automatic logic row_out(input logic signed [RW-1:0] r, input logic [WW-1:0] h);
    return r[RW-1] || (r >= $signed({1'b0, h}));
  endfunction

  assign b     = item_i.code_byte;
  assign b_dec = b - 8'd1;

  // Register values above MAX_DIM are used as MAX_DIM.
  assign eff_w = (XW'(cfg_i.image_width) > XW'(MAX_DIM)) ? WW'(MAX_DIM)
                                                          : WW'(cfg_i.image_width);
  assign eff_h = (XW'(cfg_i.image_height) > XW'(MAX_DIM)) ? WW'(MAX_DIM)
                                                           : WW'(cfg_i.image_height);

  // A start of image replaces the state before the byte is looked at.
  always_comb begin
    if (item_i.start_of_image) begin
      cur_phase = PH_COUNT;
      cur_col   = '0;
      cur_row   = cfg_i.top_down ? '0 : ($signed({1'b0, eff_h}) - RW'(1));
      cur_rc    = '0;
      cur_lit   = '0;
      cur_pad   = 1'b0;
      cur_stop  = 1'b0;
    end else begin
      cur_phase = phase_q;
      cur_col   = col_q;
      cur_row   = row_q;
      cur_rc    = rc_q;
      cur_lit   = lit_q;
      cur_pad   = pad_q;
      cur_stop  = stop_q;
    end
  end

  // Span length and clipping against the current position.
  assign lit_n  = cfg_i.four_bit_mode ? ((cur_lit < 8'd2) ? cur_lit : 8'd2) : 8'd1;
  assign span_n = (cur_phase == PH_RUN) ? cur_rc : lit_n;
  assign avail  = eff_w - cur_col;
  assign pos_in = !row_out(cur_row, eff_h) && (cur_col < eff_w);
  assign clip_n = pos_in ? ((WW'(span_n) < avail) ? span_n : LEN_W'(avail)) : '0;

  // Row moves and the delta with column wrap.
  assign row_one      = RW'(1);
  assign row_dir_step = cfg_i.top_down ? (cur_row + row_one) : (cur_row - row_one);
  assign dy_sum       = cur_col + WW'(cur_rc);
  assign dy_wrap      = dy_sum >= eff_w;
  assign dy_amt       = {1'b0, b} + {{CODE_W{1'b0}}, dy_wrap};
  assign dy_step      = RW'(dy_amt);
  assign row_dy       = cfg_i.top_down ? (cur_row + dy_step) : (cur_row - dy_step);

  always_comb begin
    phase_d   = cur_phase;
    col_d     = cur_col;
    row_d     = cur_row;
    rc_d      = cur_rc;
    lit_d     = cur_lit;
    pad_d     = cur_pad;
    stop_d    = cur_stop;
    code_end  = 1'b0;
    emit_span = 1'b0;
    status    = ST_RUNNING;
    if (!cur_stop) begin
      case (cur_phase)
        PH_COUNT: begin
          if (b == '0) begin
            phase_d = PH_ESC;
          end else begin
            rc_d    = b;
            phase_d = PH_RUN;
          end
        end
        PH_RUN: begin
          emit_span = 1'b1;
          col_d     = cur_col + WW'(span_n);
          phase_d   = PH_COUNT;
          code_end  = 1'b1;
        end
        PH_ESC: begin
          if (b == ESC_EOL) begin
            col_d    = '0;
            row_d    = row_dir_step;
            phase_d  = PH_COUNT;
            code_end = 1'b1;
          end else if (b == ESC_EOI) begin
            stop_d = 1'b1;
            status = ST_END;
          end else if (b == ESC_DELTA) begin
            phase_d = PH_DX;
          end else begin
            // Literal data is padded to whole 16-bit words.
            lit_d   = b;
            pad_d   = cfg_i.four_bit_mode ? !b_dec[1] : b[0];
            phase_d = PH_LIT;
          end
        end
        PH_DX: begin
          rc_d    = b;
          phase_d = PH_DY;
        end
        PH_DY: begin
          col_d    = dy_wrap ? (dy_sum - eff_w) : dy_sum;
          row_d    = row_dy;
          phase_d  = PH_COUNT;
          code_end = 1'b1;
        end
        PH_LIT: begin
          emit_span = 1'b1;
          col_d     = cur_col + WW'(span_n);
          lit_d     = cur_lit - span_n;
          if (lit_d == '0) begin
            if (cur_pad) begin
              phase_d = PH_PAD;
            end else begin
              phase_d  = PH_COUNT;
              code_end = 1'b1;
            end
          end
        end
        default: begin
          // Pad byte, skipped.
          pad_d    = 1'b0;
          phase_d  = PH_COUNT;
          code_end = 1'b1;
        end
      endcase
      if (code_end) begin
        if (col_d > eff_w) begin
          stop_d = 1'b1;
          status = ST_OVERFLOW;
        end else if (row_out(row_d, eff_h)) begin
          stop_d = 1'b1;
          status = ST_ROW_RANGE;
        end
      end
    end
  end

  assign res_len     = emit_span ? clip_n : '0;
  assign res_valid_o = (res_len != '0) || (status != ST_RUNNING);
  assign span_end    = cur_col + WW'(res_len);

  always_comb begin
    res_o.status      = status;
    res_o.span_length = res_len;
    if (res_len != '0) begin
      res_o.span_col   = POS_W'(cur_col);
      res_o.span_row   = POS_W'(cur_row);
      res_o.color_even = cfg_i.four_bit_mode ? COLOR_W'(b[CODE_W-1:NIB_W]) : b;
      res_o.color_odd  = cfg_i.four_bit_mode ? COLOR_W'(b[NIB_W-1:0]) : b;
    end else begin
      res_o.span_col   = '0;
      res_o.span_row   = '0;
      res_o.color_even = '0;
      res_o.color_odd  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      col_q   <= '0;
      row_q   <= RW'(ROW_RST);
      rc_q    <= '0;
      lit_q   <= '0;
      pad_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      rc_q    <= rc_d;
      lit_q   <= lit_d;
      pad_q   <= pad_d;
      stop_q  <= stop_d;
    end
  end

  a_quiet_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && stop_q && !item_i.start_of_image |-> !res_valid_o)
    else $error("result produced while decoding is stopped");

  a_stop_status_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.status != ST_RUNNING) |=> stop_q)
    else $error("stop status reported but decoder not stopped");

  a_span_inside_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.span_length != '0) |-> span_end <= eff_w)
    else $error("span runs past the image width");

  a_empty_means_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.span_length == '0) |-> res_o.status != ST_RUNNING)
    else $error("empty span reported without a stop");

endmodule

// ----- hw/rtl/brd_out_stage.sv -----
// Result register: holds one span until the receiver takes it.
module brd_out_stage import brd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  logic     res_valid_i,
  input  span_t    res_i,
  output logic     space_o,
  brd_out_if.source span_o
);

  logic  valid_q;
  span_t span_q;

  assign space_o = !valid_q || span_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (span_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      span_q <= res_i;
    end
  end

  assign span_o.valid       = valid_q;
  assign span_o.span_col    = span_q.span_col;
  assign span_o.span_row    = span_q.span_row;
  assign span_o.span_length = span_q.span_length;
  assign span_o.color_even  = span_q.color_even;
  assign span_o.color_odd   = span_q.color_odd;
  assign span_o.status      = span_q.status;

endmodule

// ----- hw/rtl/bmp_rle_decoder.sv -----
// Top level of the bitmap RLE8/RLE4 span decoder.
//
// The code_i channel takes the compressed pixel stream one item (one code byte)
// at a time; start_of_image on an item restarts the parser and the position
// before that byte is used. The span_o channel gives at most one item per code
// byte: a horizontal span of pixels, clipped to the row, with two alternating
// palette indices, or a stop report in its status field. The configuration
// port writes image width, height, RLE4 mode and row direction; the user must
// ensure it is written only while no item is in flight, unchecked by the block.
//
// A span reaches span_o from its code byte through the input register, then
// the parser into the result register, which drives span_o. Throughput is one
// code byte per cycle while the receiver takes each span, set by the parser's
// single per-byte update of its phase, position and counters. When the
// receiver stalls the result register holds its span and the parser waits,
// whatever the next byte is; the input register holds at most one more item,
// then the input side stops until the span is taken.
//
// Reset empties both registers, loads the register defaults (640 by 480,
// RLE8, bottom-up) and puts the parser at the bottom row, column zero.
module bmp_rle_decoder import brd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  brd_in_if.sink               code_i,
  brd_out_if.source            span_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 2'd3;

  cfg_t  cfg_q;
  item_t item;
  span_t res;
  logic  item_valid, out_space, step, res_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= CFG_W'(WIDTH_RST);
      cfg_q.image_height  <= CFG_W'(HEIGHT_RST);
      cfg_q.four_bit_mode <= 1'b0;
      cfg_q.top_down      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_q.image_width   <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_q.image_height  <= cfg_data_i;
        CFG_FOUR_BIT:     cfg_q.four_bit_mode <= cfg_data_i[0];
        CFG_TOP_DOWN:     cfg_q.top_down      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The held byte is parsed whenever the result register can take its outcome.
  assign step = item_valid && out_space;

  brd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_i),
    .take_i  (step),
    .valid_o (item_valid),
    .item_o  (item)
  );

  brd_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  brd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .span_o      (span_o)
  );

endmodule
